// ===== sv/peak_half_width_finder_assert.svh =====
// ----------------------------------------------------------------------------
// peak half width finder assertion macros
// shared property forms, sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef PEAK_HALF_WIDTH_FINDER_ASSERT_SVH
`define PEAK_HALF_WIDTH_FINDER_ASSERT_SVH

// consequent must hold in the same cycle
`define PHWF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phwf assertion failed");

// consequent must hold in the next cycle
`define PHWF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phwf assertion failed");

`endif

// ===== sv/phwf_pkg.sv =====
// ----------------------------------------------------------------------------
// phwf_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phwf_pkg;

    localparam int MAX_POINTS_DEF = 1024;

    localparam int X_W = 32;
    localparam int Y_W = 24;

    // function codes of an input item
    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_APPEND  = 2'd1;
    localparam logic [1:0] FUNC_MEASURE = 2'd2;

    // interpolation operand widths
    localparam int A_W    = 26;             // |H - 2*ya|
    localparam int B_W    = 32;             // |xb - xa|
    localparam int D_W    = 26;             // |2*(yb - ya)|
    localparam int PROD_W = A_W + B_W;      // product and quotient
    localparam int STEP_W = 6;

    localparam int MUL_STEPS = A_W;
    localparam int DIV_STEPS = PROD_W;

    typedef struct packed {
        logic clear;
        logic append;
        logic measure_load;
        logic idx_last;
        logic idx_first;
        logic idx_dec;
        logic idx_inc;
        logic prev_load;
        logic side_right;
        logic opnd_load;
        logic calc_start;
        logic store_side;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic few;
        logic at_first;
        logic at_last;
        logic hit;
        logic calc_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/phwf_ram.sv =====
// ----------------------------------------------------------------------------
// phwf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/phwf_muldiv.sv =====
// ----------------------------------------------------------------------------
// phwf_muldiv
// iterative unit: shift-add multiply of two magnitudes, then restoring divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phwf_muldiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [phwf_pkg::A_W-1:0]    a_mag,
    input  wire logic [phwf_pkg::B_W-1:0]    b_mag,
    input  wire logic [phwf_pkg::D_W-1:0]    d_mag,
    output logic                             done,
    output logic      [phwf_pkg::PROD_W-1:0] quot
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    localparam int PW = phwf_pkg::PROD_W;
    localparam int DW = phwf_pkg::D_W;
    localparam int SW = phwf_pkg::STEP_W;

    logic [1:0]                  phase_reg, phase_next;
    logic [SW-1:0]               step_reg, step_next;
    logic                        done_reg, done_next;
    logic [PW-1:0]               acc_reg, acc_next;
    logic [PW-1:0]               mcand_reg, mcand_next;
    logic [phwf_pkg::A_W-1:0]    mplier_reg, mplier_next;
    logic [DW:0]                 rem_reg, rem_next;
    logic [DW:0]                 rem_sh;
    logic                        ge;

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        rem_sh      = {rem_reg[DW-1:0], acc_reg[PW-1]};
        ge          = rem_sh >= {1'b0, d_mag};
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = {{(PW - phwf_pkg::B_W){1'b0}}, b_mag};
                    mplier_next = a_mag;
                    step_next   = '0;
                    phase_next  = PH_MUL;
                end
            end
            PH_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[phwf_pkg::A_W-1:1]};
                if (step_reg == SW'(phwf_pkg::MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    phase_next = PH_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            PH_DIV:
            begin
                // quotient bits shift in behind the dividend
                rem_next = ge ? (rem_sh - {1'b0, d_mag}) : rem_sh;
                acc_next = {acc_reg[PW-2:0], ge};
                if (step_reg == SW'(phwf_pkg::DIV_STEPS - 1))
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

`default_nettype wire

// ===== sv/phwf_datapath.sv =====
// ----------------------------------------------------------------------------
// phwf_datapath
// point store, scan index, crossing test, interpolation and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phwf_datapath #(
    parameter int MAX_POINTS = phwf_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire phwf_pkg::cmd_t                      cmd,
    output phwf_pkg::stat_t                          stat,
    input  wire logic [phwf_pkg::X_W-1:0]            x_value,
    input  wire logic signed [phwf_pkg::Y_W-1:0]     y_value,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic                                     found,
    output logic      [phwf_pkg::X_W-1:0]            left_x,
    output logic      [phwf_pkg::X_W-1:0]            right_x,
    output logic      [phwf_pkg::X_W-1:0]            width
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = phwf_pkg::X_W;
    localparam int YW = phwf_pkg::Y_W;
    localparam int PW = phwf_pkg::PROD_W;
    localparam int RW = PW + 2;

    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        last_idx;
    logic [CW-1:0]        count_m1;
    logic                 room;

    logic [XW-1:0]        peak_x_reg;
    logic signed [YW-1:0] peak_h_reg;
    logic [XW-1:0]        prev_x_reg;
    logic signed [YW-1:0] prev_y_reg;

    logic [XW+YW-1:0]     rdata;
    logic [XW-1:0]        rd_x;
    logic signed [YW-1:0] rd_y;

    logic signed [phwf_pkg::A_W-1:0] h2, ya2, yb2, d_a, d_y;
    logic signed [XW:0]              d_x;
    logic                            x_ok, crosses;

    logic [XW-1:0]              xa_reg;
    logic                       neg_reg, flat_reg;
    logic [phwf_pkg::A_W-1:0]   a_mag_reg;
    logic [phwf_pkg::B_W-1:0]   b_mag_reg;
    logic [phwf_pkg::D_W-1:0]   d_mag_reg;

    logic                       calc_done;
    logic [PW-1:0]              quot;
    logic signed [RW-1:0]       sq, sum;
    logic [XW-1:0]              res_x;

    logic                       have_l_reg, have_r_reg;
    logic [XW-1:0]              lx_reg, rx_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       found_reg;
    logic [XW-1:0]              left_reg, right_reg, width_reg;

    assign count_m1 = count_reg - 1'b1;
    assign last_idx = count_m1[AW-1:0];
    assign room     = count_reg < CW'(MAX_POINTS);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append && room)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_last)
        begin
            idx_next = last_idx;
        end
        else if (cmd.idx_first)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    phwf_ram #(
        .WIDTH (XW + YW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.append && room),
        .waddr (count_reg[AW-1:0]),
        .wdata ({x_value, y_value}),
        .raddr (idx_next),
        .rdata (rdata)
    );

    assign rd_x = rdata[XW+YW-1:YW];
    assign rd_y = rdata[YW-1:0];

    // prev holds the point the scan just left, rdata the one it moved to
    always_comb
    begin
        h2    = {{2{peak_h_reg[YW-1]}}, peak_h_reg};
        ya2   = {prev_y_reg[YW-1], prev_y_reg, 1'b0};
        yb2   = {rd_y[YW-1], rd_y, 1'b0};
        d_a   = h2 - ya2;
        d_y   = yb2 - ya2;
        d_x   = $signed({1'b0, rd_x}) - $signed({1'b0, prev_x_reg});
        x_ok  = cmd.side_right ? (prev_x_reg > peak_x_reg) : (prev_x_reg < peak_x_reg);
        crosses = ((ya2 >= h2) && (yb2 <= h2)) || ((ya2 <= h2) && (yb2 >= h2));
    end

    phwf_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.calc_start),
        .a_mag (a_mag_reg),
        .b_mag (b_mag_reg),
        .d_mag (d_mag_reg),
        .done  (calc_done),
        .quot  (quot)
    );

    // signed quotient added to xa, then clamped to the unsigned x range; a flat segment gives xa
    always_comb
    begin
        sq  = neg_reg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        sum = $signed({{(RW - XW){1'b0}}, xa_reg}) + sq;
        if (flat_reg)
        begin
            res_x = xa_reg;
        end
        else if (sum[RW-1])
        begin
            res_x = '0;
        end
        else if (|sum[RW-2:XW])
        begin
            res_x = '1;
        end
        else
        begin
            res_x = sum[XW-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            have_l_reg    <= 1'b0;
            have_r_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.measure_load)
            begin
                have_l_reg <= 1'b0;
                have_r_reg <= 1'b0;
            end
            else if (cmd.store_side)
            begin
                if (cmd.side_right)
                begin
                    have_r_reg <= 1'b1;
                end
                else
                begin
                    have_l_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.measure_load)
        begin
            peak_x_reg <= x_value;
            peak_h_reg <= y_value;
        end
        if (cmd.prev_load)
        begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (cmd.opnd_load)
        begin
            xa_reg    <= prev_x_reg;
            neg_reg   <= d_a[phwf_pkg::A_W-1] ^ d_x[XW] ^ d_y[phwf_pkg::A_W-1];
            flat_reg  <= (d_y == '0);
            a_mag_reg <= d_a[phwf_pkg::A_W-1] ? 26'(-d_a) : 26'(d_a);
            b_mag_reg <= d_x[XW] ? 32'(-d_x) : d_x[XW-1:0];
            d_mag_reg <= d_y[phwf_pkg::A_W-1] ? 26'(-d_y) : 26'(d_y);
        end
        if (cmd.store_side)
        begin
            if (cmd.side_right)
            begin
                rx_reg <= res_x;
            end
            else
            begin
                lx_reg <= res_x;
            end
        end
        if (cmd.out_load)
        begin
            found_reg <= have_l_reg && have_r_reg;
            if (have_l_reg && have_r_reg)
            begin
                left_reg  <= lx_reg;
                right_reg <= rx_reg;
                width_reg <= (rx_reg > lx_reg) ? (rx_reg - lx_reg) : '0;
            end
            else
            begin
                left_reg  <= '0;
                right_reg <= '0;
                width_reg <= '0;
            end
        end
    end

    always_comb
    begin
        stat.few       = count_reg < CW'(2);
        stat.at_first  = idx_reg == '0;
        stat.at_last   = idx_reg == last_idx;
        stat.hit       = x_ok && crosses;
        stat.calc_done = calc_done;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign left_x    = left_reg;
    assign right_x   = right_reg;
    assign width     = width_reg;

endmodule

`default_nettype wire

// ===== sv/phwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// phwf_ctrl
// sequencer: item decode, left and right scans, interpolation and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phwf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [1:0]      func,
    output logic                 in_stall,
    input  wire phwf_pkg::stat_t stat,
    output phwf_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_L_PRIME   = 4'd1;
    localparam logic [3:0] S_L_SCAN    = 4'd2;
    localparam logic [3:0] S_R_PRIME   = 4'd3;
    localparam logic [3:0] S_R_SCAN    = 4'd4;
    localparam logic [3:0] S_CALC_GO   = 4'd5;
    localparam logic [3:0] S_CALC_WAIT = 4'd6;
    localparam logic [3:0] S_DONE      = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       side_reg, side_next;

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        phwf_pkg::FUNC_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        phwf_pkg::FUNC_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        phwf_pkg::FUNC_MEASURE:
                        begin
                            cmd.measure_load = 1'b1;
                            cmd.idx_last     = 1'b1;
                            state_next       = stat.few ? S_DONE : S_L_PRIME;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_L_PRIME:
            begin
                cmd.prev_load = 1'b1;
                cmd.idx_dec   = 1'b1;
                state_next    = S_L_SCAN;
            end
            S_L_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.opnd_load = 1'b1;
                    side_next     = 1'b0;
                    state_next    = S_CALC_GO;
                end
                else if (stat.at_first)
                begin
                    cmd.idx_first = 1'b1;
                    state_next    = S_R_PRIME;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_dec   = 1'b1;
                end
            end
            S_R_PRIME:
            begin
                cmd.prev_load = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = S_R_SCAN;
            end
            S_R_SCAN:
            begin
                cmd.side_right = 1'b1;
                if (stat.hit)
                begin
                    cmd.opnd_load = 1'b1;
                    side_next     = 1'b1;
                    state_next    = S_CALC_GO;
                end
                else if (stat.at_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                end
            end
            S_CALC_GO:
            begin
                cmd.calc_start = 1'b1;
                state_next     = S_CALC_WAIT;
            end
            S_CALC_WAIT:
            begin
                cmd.side_right = side_reg;
                if (stat.calc_done)
                begin
                    cmd.store_side = 1'b1;
                    if (side_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_first = 1'b1;
                        state_next    = S_R_PRIME;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

`default_nettype wire

// ===== sv/peak_half_width_finder.sv =====
// ----------------------------------------------------------------------------
// peak_half_width_finder
// Holds a curve of up to MAX_POINTS (x, y) points appended in ascending x and
// measures a peak's full width at half height by linear interpolation. Clear
// and append items are taken while idle. A measure item on a curve of n points
// scans from the last point down for the left crossing and from the first
// point up for the right crossing, one stored point per cycle from a single
// read port, and each crossing found runs an iterative multiply and divide;
// one result follows each measure. The result sits in an output register, so
// a new item is taken while it waits, and a later measure holds until the
// register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "peak_half_width_finder_assert.svh"

module peak_half_width_finder #(
    parameter int MAX_POINTS = phwf_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       func,
    input  wire logic [phwf_pkg::X_W-1:0]         x_value,
    input  wire logic signed [phwf_pkg::Y_W-1:0]  y_value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  found,
    output logic      [phwf_pkg::X_W-1:0]         left_x,
    output logic      [phwf_pkg::X_W-1:0]         right_x,
    output logic      [phwf_pkg::X_W-1:0]         width
);

    phwf_pkg::cmd_t  cmd;
    phwf_pkg::stat_t stat;

    phwf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    phwf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .x_value   (x_value),
        .y_value   (y_value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .found     (found),
        .left_x    (left_x),
        .right_x   (right_x),
        .width     (width)
    );

    // a miss reports all-zero positions
    `PHWF_ASSERT_NOW(a_miss_zero, out_valid && !found, (left_x == '0) && (right_x == '0) && (width == '0))
    // width is the distance between the two crossings
    `PHWF_ASSERT_NOW(a_width_diff, out_valid && found && (right_x >= left_x), width == (right_x - left_x))
    // the interpolation unit never answers in the cycle after its start
    `PHWF_ASSERT_NEXT(a_calc_latency, cmd.calc_start, !stat.calc_done)
    // a result is only loaded into a free output register
    `PHWF_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid || !out_stall)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// peak half width testbench
// Builds curves of rising and falling points, measures peaks against them and
// checks each half-height crossing and width against a predictor kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NPTS = 1024;
    localparam int LONG_LEN = 48;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic        found;
        logic [31:0] left_x;
        logic [31:0] right_x;
        logic [31:0] width;
    } fwhm_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] func;
    logic [31:0] x_value;
    logic signed [23:0] y_value;
    logic out_valid;
    logic out_stall;
    logic found;
    logic [31:0] left_x;
    logic [31:0] right_x;
    logic [31:0] width;

    logic [31:0] curve_x [NPTS];
    logic signed [23:0] curve_y [NPTS];
    int unsigned curve_len;
    fwhm_t expected_fwhm [$];
    int errors;
    int measures_sent;
    int results_seen;
    int idle_cycles;
    int stall_mode;

    peak_half_width_finder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .x_value(x_value), .y_value(y_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .left_x(left_x), .right_x(right_x), .width(width)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit seg_crosses(longint ya, longint yb, longint h);
        longint a;
        longint b;
        a = 2 * ya;
        b = 2 * yb;
        return (a >= h && b <= h) || (a <= h && b >= h);
    endfunction

    function automatic logic [31:0] crossing_x(longint xa, longint ya, longint xb,
                                               longint yb, longint h);
        longint dy2;
        longint r;
        dy2 = 2 * (yb - ya);
        if (dy2 == 0)
            return xa[31:0];
        r = xa + ((h - 2 * ya) * (xb - xa)) / dy2;
        if (r < 0)
            r = 0;
        if (r > 64'sh0_FFFF_FFFF)
            r = 64'sh0_FFFF_FFFF;
        return r[31:0];
    endfunction

    function automatic fwhm_t measure_curve(logic [31:0] px, logic signed [23:0] h);
        fwhm_t res;
        bit have_l;
        bit have_r;
        logic [31:0] lx;
        logic [31:0] rx;
        int k;
        have_l = 0;
        have_r = 0;
        lx = 0;
        rx = 0;
        res = '0;
        for (k = int'(curve_len) - 1; k >= 1 && !have_l; k--)
            if (curve_x[k] < px && seg_crosses(curve_y[k], curve_y[k-1], h))
            begin
                lx = crossing_x(curve_x[k], curve_y[k], curve_x[k-1], curve_y[k-1], h);
                have_l = 1;
            end
        for (k = 0; k + 1 < int'(curve_len) && !have_r; k++)
            if (curve_x[k] > px && seg_crosses(curve_y[k], curve_y[k+1], h))
            begin
                rx = crossing_x(curve_x[k], curve_y[k], curve_x[k+1], curve_y[k+1], h);
                have_r = 1;
            end
        if (have_l && have_r)
        begin
            res.found = 1'b1;
            res.left_x = lx;
            res.right_x = rx;
            res.width = (rx > lx) ? rx - lx : 32'd0;
        end
        return res;
    endfunction

    // one item; bursts with random gaps in front
    task automatic send_item(logic [1:0] f, logic [31:0] xv, logic signed [23:0] yv);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        x_value <= xv;
        y_value <= yv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (f)
            phwf_pkg::FUNC_CLEAR: curve_len = 0;
            phwf_pkg::FUNC_APPEND:
                if (curve_len < NPTS)
                begin
                    curve_x[curve_len] = xv;
                    curve_y[curve_len] = yv;
                    curve_len++;
                end
            phwf_pkg::FUNC_MEASURE:
            begin
                expected_fwhm.push_back(measure_curve(xv, yv));
                measures_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_fwhm.size() != 0)
            @(posedge clk);
    endtask

    // peak-shaped curve of n points with ascending x, random content
    task automatic build_peak(int n, int unsigned x0, int unsigned step,
                              int signed top, output int unsigned px);
        int i;
        int mid;
        int signed y;
        send_item(phwf_pkg::FUNC_CLEAR, $urandom, 24'($urandom));
        mid = $urandom_range(0, n - 1);
        px = x0 + mid * step + step / 2;
        for (i = 0; i < n; i++)
        begin
            y = top - (i > mid ? i - mid : mid - i) * (top / (n / 2 + 1))
                + $signed($urandom_range(0, 40)) - 20;
            send_item(phwf_pkg::FUNC_APPEND, x0 + i * step + $urandom_range(0, step / 4),
                      y[23:0]);
        end
    endtask

    task automatic test_directed();
        int unsigned px;
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0001_0000, 24'sd100);      // empty curve
        send_item(phwf_pkg::FUNC_APPEND, 32'h0001_0000, 24'sd10);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0001_8000, 24'sd10);       // one point only
        send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 24'sh7FFFFF);
        send_item(phwf_pkg::FUNC_APPEND, 32'h0002_0000, 24'sd50);
        send_item(phwf_pkg::FUNC_APPEND, 32'h0003_0000, 24'sd50);        // flat top
        send_item(phwf_pkg::FUNC_APPEND, 32'h0004_0000, 24'sd10);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0002_8000, 24'sd50);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0002_8000, 24'sd100);      // flat crossing
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0000_0000, 24'sd40);
        send_item(phwf_pkg::FUNC_MEASURE, 32'hFFFF_FFFF, 24'sd40);
        send_item(phwf_pkg::FUNC_CLEAR, 32'h0, 24'sd0);
        send_item(phwf_pkg::FUNC_APPEND, 32'h0000_0000, 24'sh800000);
        send_item(phwf_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 24'sh7FFFFF);
        send_item(phwf_pkg::FUNC_APPEND, 32'hFFFF_FFFF, 24'sh800000);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h8000_0000, 24'sh7FFFFF);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h8000_0000, 24'sh800000);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h4000_0000, 24'sd0);
        drain();
        build_peak(6, 32'h0010_0000, 32'h0001_0000, 24'sd1000, px);
        send_item(phwf_pkg::FUNC_MEASURE, px, 24'sd1000);
    endtask

    // longer triangle so both scans walk many points
    task automatic test_long_curve();
        int i;
        send_item(phwf_pkg::FUNC_CLEAR, '0, '0);
        for (i = 0; i < LONG_LEN; i++)
            send_item(phwf_pkg::FUNC_APPEND, 32'(i) * 32'h0000_1000,
                      24'((i < LONG_LEN / 2) ? i * 8 : (LONG_LEN - i) * 8));
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0001_8000, 24'sd192);
        send_item(phwf_pkg::FUNC_MEASURE, 32'h0001_8000, 24'sd300);
    endtask

    task automatic test_random();
        int unsigned px;
        int b;
        int j;
        for (b = 0; b < 22; b++)
        begin
            if ($urandom_range(0, 4) == 0)
                // noise items with random content
                for (j = 0; j < 4; j++)
                    send_item(2'($urandom_range(0, 3)), $urandom, 24'($urandom));
            else
            begin
                build_peak($urandom_range(2, 10), $urandom_range(0, 32'h8000_0000),
                           $urandom_range(1, 32'h0100_0000),
                           $urandom_range(100, 24'h7FFF00), px);
                for (j = 0; j < 3; j++)
                    send_item(phwf_pkg::FUNC_MEASURE,
                              ($urandom_range(0, 2) == 0) ? $urandom : px,
                              24'(($urandom_range(0, 2) == 0) ? $urandom
                                                              : $urandom_range(0, 24'hFFFFFF)));
            end
            if (b == 10)
                drain();
        end
    endtask

    // receiver stall pattern changes over the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
    end

    always @(posedge clk)
        if (rst_n && (in_valid && !in_stall || out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;

    always @(posedge clk)
    begin
        fwhm_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_fwhm.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b left=%h right=%h width=%h",
                         $time, found, left_x, right_x, width);
                errors++;
            end
            else
            begin
                want = expected_fwhm.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, found);
                    errors++;
                end
                if (left_x !== want.left_x)
                begin
                    $display("%0t: left_x expected %h actual %h", $time, want.left_x, left_x);
                    errors++;
                end
                if (right_x !== want.right_x)
                begin
                    $display("%0t: right_x expected %h actual %h", $time, want.right_x,
                             right_x);
                    errors++;
                end
                if (width !== want.width)
                begin
                    $display("%0t: width expected %h actual %h", $time, want.width, width);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog timeout", $time);
            $display("Some tests failed");
            $finish;
        end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = phwf_pkg::FUNC_CLEAR;
        x_value = '0;
        y_value = '0;
        curve_len = 0;
        errors = 0;
        measures_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        stall_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_mode = 1;
        test_long_curve();
        stall_mode = 2;
        test_random();
        stall_mode = 1;
        drain();
        repeat (300) @(posedge clk);
        $display("covered %0d measures with %0d results over short, long and flat curves",
                 measures_sent, results_seen);
        if (errors == 0 && expected_fwhm.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
